[src/ole_pkg.sv]
// Package for the ordered list engine: operation and status codes, field widths.
// Used by every module of the block but ole_ram; depends on nothing.
package ole_pkg;

  localparam int OP_W        = 4;
  localparam int VALUE_W     = 32;
  localparam int ST_W        = 2;
  localparam int POS_W       = 5;
  localparam int MAX_RESULTS = 32;

  typedef logic [OP_W-1:0]    op_t;
  typedef logic [ST_W-1:0]    status_t;
  typedef logic [VALUE_W-1:0] value_t;

  localparam op_t OP_INS_HEAD  = 4'd0;
  localparam op_t OP_INS_TAIL  = 4'd1;
  localparam op_t OP_INS_AFTER = 4'd2;
  localparam op_t OP_SEARCH    = 4'd3;
  localparam op_t OP_TRAVERSE  = 4'd4;
  localparam op_t OP_DEL_HEAD  = 4'd5;
  localparam op_t OP_DEL_TAIL  = 4'd6;
  localparam op_t OP_DEL_VALUE = 4'd7;
  localparam op_t OP_CLEAR     = 4'd8;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_EMPTY    = 2'd1;
  localparam status_t ST_NOTFOUND = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

endpackage

[src/ordered_list_engine_unit.sv]
// Top level of the ordered list engine: a singly linked list in a pool of slots.
// Depends on ole_pkg and ole_ram (value memory and link memory).
//
//  Channel  | Ports                                        | Beat taken when
//  ---------+----------------------------------------------+-------------------------
//  input    | start, busy, in_operation, in_new_value,     | start high, busy low
//           | in_match_value                               |
//  result   | out_valid, out_status, out_element_value,    | every cycle out_valid is
//           | out_position, out_last_of_run                | high (no back-pressure)
//
// A small sequencer drives one memory read per cycle through the linked slots.
// Search, insert-after and delete-value walk the list until a match or its end;
// traverse emits its beats back to back; delete-tail stops before the tail.
// Inserts scan eight slots at a time for the lowest free one, write the node
// and a second link if needed; answers decided at start come in the next cycle.
// Reset is synchronous and empties the list; memory contents are not cleared.
// The receiver cannot stall; busy stays high until the final beat is issued.
module ordered_list_engine_unit #(
  parameter int DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  ole_pkg::op_t                  in_operation,
  input  logic signed [31:0]            in_new_value,
  input  logic signed [31:0]            in_match_value,
  output logic                          out_valid,
  output ole_pkg::status_t              out_status,
  output logic signed [31:0]            out_element_value,
  output logic [ole_pkg::POS_W-1:0]     out_position,
  output logic                          out_last_of_run
);

  localparam int SW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int CHUNKS = (DEPTH + 7) / 8;
  localparam int CHW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FIND   = 3'd1;
  localparam logic [2:0] S_TRAV   = 3'd2;
  localparam logic [2:0] S_WALKT  = 3'd3;
  localparam logic [2:0] S_DHEAD  = 3'd4;
  localparam logic [2:0] S_ALLOC  = 3'd5;
  localparam logic [2:0] S_COMMIT = 3'd6;
  localparam logic [2:0] S_LINK2  = 3'd7;

  logic [2:0]          state_r, state_nxt;
  ole_pkg::op_t        op_r, op_nxt;
  ole_pkg::value_t     nv_r, nv_nxt, mv_r, mv_nxt;
  logic [SW-1:0]       head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [DEPTH-1:0]    used_r, used_nxt;
  logic [SW-1:0]       cur_r, cur_nxt, prev_r, prev_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [SW-1:0]       fslot_r, fslot_nxt, fnext_r, fnext_nxt, nslot_r, nslot_nxt;
  logic [CW-1:0]       fpos_r, fpos_nxt;
  logic [CHW-1:0]      chunk_r, chunk_nxt;

  logic                     out_valid_r, out_valid_nxt;
  ole_pkg::status_t         out_status_r, out_status_nxt;
  ole_pkg::value_t          out_elem_r, out_elem_nxt;
  logic [ole_pkg::POS_W-1:0] out_pos_r, out_pos_nxt;
  logic                     out_last_r, out_last_nxt;

  // Memory ports.
  logic                 v_we, l_we;
  logic [SW-1:0]        v_waddr, l_waddr, raddr;
  ole_pkg::value_t      v_wdata, v_rdata;
  logic [SW-1:0]        l_wdata, l_rdata;

  // Free-slot scan, eight slots per cycle.
  logic [CHUNKS*8-1:0]  pmap;
  logic [7:0]           scan_byte;
  logic [2:0]           first_zero;
  logic                 byte_has_free;

  logic                 full, empty, match, trav_last, walk_done;

  ole_ram #(.WIDTH(ole_pkg::VALUE_W), .DEPTH(DEPTH)) u_value_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (raddr),
    .rdata (v_rdata)
  );

  ole_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (raddr),
    .rdata (l_rdata)
  );

  always_comb begin
    pmap = '1;
    pmap[DEPTH-1:0] = used_r;
    scan_byte = pmap[chunk_r*8 +: 8];
    byte_has_free = (scan_byte != 8'hFF);
    first_zero = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (!scan_byte[k]) begin
        first_zero = 3'(k);
      end
    end
  end

  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign match     = (v_rdata == mv_r);
  assign trav_last = (({1'b0, idx_r} + (CW+1)'(1)) == {1'b0, count_r}) ||
                     (32'(idx_r) == 32'(ole_pkg::MAX_RESULTS - 1));
  assign walk_done = (({1'b0, idx_r} + (CW+1)'(2)) == {1'b0, count_r});

  // The walk presents the link just read as the next address, so one slot
  // is visited per cycle.
  always_comb begin
    case (state_r)
      S_FIND, S_TRAV, S_WALKT: raddr = l_rdata;
      default:                 raddr = head_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    nv_nxt    = nv_r;
    mv_nxt    = mv_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    used_nxt  = used_r;
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    idx_nxt   = idx_r;
    fslot_nxt = fslot_r;
    fnext_nxt = fnext_r;
    fpos_nxt  = fpos_r;
    nslot_nxt = nslot_r;
    chunk_nxt = chunk_r;

    out_valid_nxt  = 1'b0;
    out_status_nxt = ole_pkg::ST_OK;
    out_elem_nxt   = '0;
    out_pos_nxt    = '0;
    out_last_nxt   = 1'b1;

    v_we    = 1'b0;
    v_waddr = nslot_r;
    v_wdata = nv_r;
    l_we    = 1'b0;
    l_waddr = nslot_r;
    l_wdata = '0;

    case (state_r)
      S_IDLE: begin
        op_nxt    = in_operation;
        nv_nxt    = in_new_value;
        mv_nxt    = in_match_value;
        cur_nxt   = head_r;
        prev_nxt  = head_r;
        idx_nxt   = '0;
        chunk_nxt = '0;
        if (start) begin
          if ((in_operation inside {[ole_pkg::OP_INS_AFTER:ole_pkg::OP_DEL_VALUE]}) &&
              empty) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ole_pkg::ST_EMPTY;
          end else begin
            case (in_operation)
              ole_pkg::OP_INS_HEAD, ole_pkg::OP_INS_TAIL: begin
                if (full) begin
                  out_valid_nxt  = 1'b1;
                  out_status_nxt = ole_pkg::ST_FULL;
                end else begin
                  state_nxt = S_ALLOC;
                end
              end
              ole_pkg::OP_INS_AFTER, ole_pkg::OP_SEARCH, ole_pkg::OP_DEL_VALUE: begin
                state_nxt = S_FIND;
              end
              ole_pkg::OP_TRAVERSE: state_nxt = S_TRAV;
              ole_pkg::OP_DEL_HEAD: state_nxt = S_DHEAD;
              ole_pkg::OP_DEL_TAIL: begin
                state_nxt = (count_r == CW'(1)) ? S_DHEAD : S_WALKT;
              end
              ole_pkg::OP_CLEAR: begin
                used_nxt      = '0;
                head_nxt      = '0;
                tail_nxt      = '0;
                count_nxt     = '0;
                out_valid_nxt = 1'b1;
              end
              default: out_valid_nxt = 1'b1;
            endcase
          end
        end
      end

      S_FIND: begin
        if (idx_r == count_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ole_pkg::ST_NOTFOUND;
          state_nxt      = S_IDLE;
        end else if (match) begin
          case (op_r)
            ole_pkg::OP_INS_AFTER: begin
              if (full) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ole_pkg::ST_FULL;
                state_nxt      = S_IDLE;
              end else begin
                fslot_nxt = cur_r;
                fnext_nxt = l_rdata;
                fpos_nxt  = idx_r;
                chunk_nxt = '0;
                state_nxt = S_ALLOC;
              end
            end
            ole_pkg::OP_DEL_VALUE: begin
              if (idx_r == '0) begin
                head_nxt = l_rdata;
              end else begin
                l_we    = 1'b1;
                l_waddr = prev_r;
                l_wdata = l_rdata;
                if (cur_r == tail_r) begin
                  tail_nxt = prev_r;
                end
              end
              used_nxt[cur_r] = 1'b0;
              count_nxt       = count_r - 1'b1;
              if (count_r == CW'(1)) begin
                head_nxt = '0;
                tail_nxt = '0;
              end
              out_valid_nxt = 1'b1;
              out_pos_nxt   = ole_pkg::POS_W'(idx_r);
              state_nxt     = S_IDLE;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_pos_nxt   = ole_pkg::POS_W'(idx_r);
              state_nxt     = S_IDLE;
            end
          endcase
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = l_rdata;
          idx_nxt  = idx_r + 1'b1;
        end
      end

      S_TRAV: begin
        out_valid_nxt = 1'b1;
        out_elem_nxt  = v_rdata;
        out_pos_nxt   = ole_pkg::POS_W'(idx_r);
        out_last_nxt  = trav_last;
        if (trav_last) begin
          state_nxt = S_IDLE;
        end else begin
          cur_nxt = l_rdata;
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_WALKT: begin
        // Stops on the node just before the tail.
        if (walk_done) begin
          l_we             = 1'b1;
          l_waddr          = cur_r;
          l_wdata          = '0;
          used_nxt[tail_r] = 1'b0;
          tail_nxt         = cur_r;
          count_nxt        = count_r - 1'b1;
          out_valid_nxt    = 1'b1;
          state_nxt        = S_IDLE;
        end else begin
          cur_nxt = l_rdata;
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_DHEAD: begin
        head_nxt         = l_rdata;
        used_nxt[head_r] = 1'b0;
        count_nxt        = count_r - 1'b1;
        if (count_r == CW'(1)) begin
          head_nxt = '0;
          tail_nxt = '0;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_ALLOC: begin
        if (byte_has_free) begin
          nslot_nxt = SW'({chunk_r, first_zero});
          state_nxt = S_COMMIT;
        end else begin
          chunk_nxt = chunk_r + 1'b1;
        end
      end

      S_COMMIT: begin
        v_we              = 1'b1;
        l_we              = 1'b1;
        used_nxt[nslot_r] = 1'b1;
        case (op_r)
          ole_pkg::OP_INS_HEAD: begin
            l_wdata   = head_r;
            head_nxt  = nslot_r;
            if (empty) begin
              tail_nxt = nslot_r;
            end
            count_nxt     = count_r + 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
          ole_pkg::OP_INS_TAIL: begin
            l_wdata = '0;
            if (empty) begin
              head_nxt      = nslot_r;
              tail_nxt      = nslot_r;
              count_nxt     = count_r + 1'b1;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              state_nxt = S_LINK2;
            end
          end
          default: begin
            l_wdata   = fnext_r;
            state_nxt = S_LINK2;
          end
        endcase
      end

      S_LINK2: begin
        // Second link write: hook the new slot in behind its predecessor.
        l_we          = 1'b1;
        l_wdata       = nslot_r;
        count_nxt     = count_r + 1'b1;
        tail_nxt      = tail_r;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        case (op_r)
          ole_pkg::OP_INS_TAIL: begin
            l_waddr  = tail_r;
            tail_nxt = nslot_r;
          end
          default: begin
            l_waddr = fslot_r;
            if (fslot_r == tail_r) begin
              tail_nxt = nslot_r;
            end
            out_pos_nxt = ole_pkg::POS_W'(fpos_r);
          end
        endcase
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    nv_r         <= nv_nxt;
    mv_r         <= mv_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    idx_r        <= idx_nxt;
    fslot_r      <= fslot_nxt;
    fnext_r      <= fnext_nxt;
    fpos_r       <= fpos_nxt;
    nslot_r      <= nslot_nxt;
    chunk_r      <= chunk_nxt;
    out_status_r <= out_status_nxt;
    out_elem_r   <= out_elem_nxt;
    out_pos_r    <= out_pos_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_element_value = $signed(out_elem_r);
  assign out_position      = out_pos_r;
  assign out_last_of_run   = out_last_r;

endmodule

[src/ole_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
module ole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/ole_chk.sv]
// Port-level checker for the ordered list engine, bound to the top level.
// Depends on ole_pkg for operation and status codes.
module ole_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input ole_pkg::op_t                  in_operation,
  input logic signed [31:0]            in_new_value,
  input logic signed [31:0]            in_match_value,
  input logic                          out_valid,
  input ole_pkg::status_t              out_status,
  input logic signed [31:0]            out_element_value,
  input logic [ole_pkg::POS_W-1:0]     out_position,
  input logic                          out_last_of_run
);

  // An accepted command beat carries fully known fields.
  a_accept_known: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> !$isunknown({in_operation, in_new_value, in_match_value}))
    else $error("accepted command beat has unknown fields");

  // Every accepted beat either keeps the block busy or answers at once.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted beat neither started work nor answered");

  // Only a traverse gives more than one beat, and its non-final beats must be status ok.
  a_multi_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_of_run) |-> (out_status == ole_pkg::ST_OK))
    else $error("non-final beat carries an error status");

  // Traverse beats come back to back with consecutive positions.
  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_of_run) |=>
      (out_valid && (out_position == ole_pkg::POS_W'($past(out_position) + 1'b1))))
    else $error("traverse run broken or positions out of order");

  // Error answers carry no element and no position.
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ole_pkg::ST_OK)) |->
      ((out_element_value == 32'sd0) && (out_position == '0) && out_last_of_run))
    else $error("error beat carries payload");

endmodule

bind ordered_list_engine_unit ole_chk u_ole_chk (.*);

[dv/ordered_list_checker.sv]
// Checker for the ordered list engine: predicts every result beat and compares it.
// Watches the command and result ports beside the block; depends on ole_pkg only.
module ordered_list_checker
  import ole_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  op_t                  in_operation,
  input  logic signed [31:0]   in_new_value,
  input  logic signed [31:0]   in_match_value,
  input  logic                 out_valid,
  input  status_t              out_status,
  input  logic signed [31:0]   out_element_value,
  input  logic [POS_W-1:0]     out_position,
  input  logic                 out_last_of_run,
  output int                   fail_count,
  output int                   beats_seen,
  output int                   beats_pending
);

  typedef struct packed {
    status_t            status;
    value_t             element;
    logic [POS_W-1:0]   position;
    logic               last;
  } list_beat_t;

  // Shadow of the linked list held in the slot pool.
  value_t           node_value [DEPTH];
  int               node_link  [DEPTH];
  logic [DEPTH-1:0] slot_taken;
  int               list_head;
  int               list_tail;
  int               list_len;

  list_beat_t       beats_due [$];

  task automatic push_beat(input status_t st, input value_t v, input int pos,
                           input logic last);
    list_beat_t b;
    b.status   = st;
    b.element  = v;
    b.position = POS_W'(pos);
    b.last     = last;
    beats_due.push_back(b);
  endtask

  function automatic int take_free_slot();
    for (int i = 0; i < DEPTH; i++) begin
      if (!slot_taken[i]) begin
        slot_taken[i] = 1'b1;
        return i;
      end
    end
    return 0;
  endfunction

  // Position of the first node holding v, or -1; also its slot and predecessor.
  function automatic int locate(input value_t v, output int slot, output int prev);
    int cur;
    int pv;
    cur  = list_head;
    pv   = list_head;
    slot = 0;
    prev = 0;
    for (int i = 0; i < list_len; i++) begin
      if (node_value[cur] == v) begin
        slot = cur;
        prev = pv;
        return i;
      end
      pv  = cur;
      cur = node_link[cur];
    end
    return -1;
  endfunction

  task automatic drop_front();
    int old;
    old              = list_head;
    list_head        = node_link[old];
    slot_taken[old]  = 1'b0;
    list_len--;
    if (list_len == 0) begin
      list_head = 0;
      list_tail = 0;
    end
  endtask

  task automatic apply_command(input op_t op, input value_t nv, input value_t mv);
    int s;
    int slot;
    int prev;
    int pos;
    int cur;
    int n;
    // Everything from insert-after to delete-value needs a non-empty list.
    if (op != OP_INS_HEAD && op != OP_INS_TAIL && op <= OP_DEL_VALUE && list_len == 0) begin
      push_beat(ST_EMPTY, '0, 0, 1'b1);
      return;
    end
    case (op)
      OP_INS_HEAD, OP_INS_TAIL: begin
        if (list_len >= DEPTH) begin
          push_beat(ST_FULL, '0, 0, 1'b1);
        end else begin
          s = take_free_slot();
          node_value[s] = nv;
          if (op == OP_INS_HEAD) begin
            node_link[s] = list_head;
            if (list_len == 0) list_tail = s;
            list_head = s;
          end else begin
            node_link[s] = 0;
            if (list_len == 0) list_head = s;
            else node_link[list_tail] = s;
            list_tail = s;
          end
          list_len++;
          push_beat(ST_OK, '0, 0, 1'b1);
        end
      end
      OP_INS_AFTER: begin
        // The match is looked for before the pool is checked for room.
        pos = locate(mv, slot, prev);
        if (pos < 0) begin
          push_beat(ST_NOTFOUND, '0, 0, 1'b1);
        end else if (list_len >= DEPTH) begin
          push_beat(ST_FULL, '0, 0, 1'b1);
        end else begin
          s = take_free_slot();
          node_value[s]   = nv;
          node_link[s]    = node_link[slot];
          node_link[slot] = s;
          if (slot == list_tail) list_tail = s;
          list_len++;
          push_beat(ST_OK, '0, pos, 1'b1);
        end
      end
      OP_SEARCH: begin
        pos = locate(mv, slot, prev);
        if (pos < 0) push_beat(ST_NOTFOUND, '0, 0, 1'b1);
        else push_beat(ST_OK, '0, pos, 1'b1);
      end
      OP_TRAVERSE: begin
        n   = (list_len < MAX_RESULTS) ? list_len : MAX_RESULTS;
        cur = list_head;
        for (int i = 0; i < n; i++) begin
          push_beat(ST_OK, node_value[cur], i, (i + 1 == n));
          cur = node_link[cur];
        end
      end
      OP_DEL_HEAD: begin
        drop_front();
        push_beat(ST_OK, '0, 0, 1'b1);
      end
      OP_DEL_TAIL: begin
        if (list_len == 1) begin
          drop_front();
        end else begin
          cur = list_head;
          for (int i = 0; i + 2 < list_len; i++) cur = node_link[cur];
          slot_taken[list_tail] = 1'b0;
          node_link[cur] = 0;
          list_tail = cur;
          list_len--;
        end
        push_beat(ST_OK, '0, 0, 1'b1);
      end
      OP_DEL_VALUE: begin
        pos = locate(mv, slot, prev);
        if (pos < 0) begin
          push_beat(ST_NOTFOUND, '0, 0, 1'b1);
        end else begin
          if (pos == 0) begin
            drop_front();
          end else begin
            node_link[prev] = node_link[slot];
            if (slot == list_tail) list_tail = prev;
            slot_taken[slot] = 1'b0;
            list_len--;
          end
          push_beat(ST_OK, '0, pos, 1'b1);
        end
      end
      OP_CLEAR: begin
        slot_taken = '0;
        list_head  = 0;
        list_tail  = 0;
        list_len   = 0;
        push_beat(ST_OK, '0, 0, 1'b1);
      end
      default: begin
        push_beat(ST_OK, '0, 0, 1'b1);
      end
    endcase
  endtask

  always @(posedge clk) begin
    list_beat_t want;
    if (!rst_n) begin
      slot_taken = '0;
      list_head  = 0;
      list_tail  = 0;
      list_len   = 0;
      beats_due.delete();
    end else begin
      // The beat on the outputs belongs to an earlier command, so compare first.
      if (out_valid) begin
        beats_seen++;
        if (beats_due.size() == 0) begin
          $error("result beat with nothing expected: status %0d value %0d position %0d",
                 out_status, out_element_value, out_position);
          fail_count++;
        end else begin
          want = beats_due.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fail_count++;
          end
          if (out_element_value !== $signed(want.element)) begin
            $error("element_value: expected %0d, got %0d", $signed(want.element),
                   out_element_value);
            fail_count++;
          end
          if (out_position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, out_position);
            fail_count++;
          end
          if (out_last_of_run !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, out_last_of_run);
            fail_count++;
          end
        end
      end
      if (start && !busy) apply_command(in_operation, in_new_value, in_match_value);
    end
    beats_pending = beats_due.size();
  end

endmodule

[dv/tb_ordered_list_engine_unit.sv]
// Testbench top for the ordered list engine: drives commands and gives the verdict.
// Depends on ole_pkg, ordered_list_engine_unit and ordered_list_checker.
module tb_ordered_list_engine_unit;
  import ole_pkg::*;

  localparam int     DEPTH       = 32;
  localparam int     STALL_LIMIT = 4000;
  localparam int     MIXED_ITEMS = 35;
  localparam value_t ABSENT      = 32'h5A5A_0001;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  op_t                 in_operation;
  logic signed [31:0]  in_new_value;
  logic signed [31:0]  in_match_value;
  logic                out_valid;
  status_t             out_status;
  logic signed [31:0]  out_element_value;
  logic [POS_W-1:0]    out_position;
  logic                out_last_of_run;

  int     fail_count;
  int     beats_seen;
  int     beats_pending;
  int     sent_count;
  int     quiet_cycles;
  int     idle_pct;
  value_t value_pool [8];

  ordered_list_engine_unit #(.DEPTH(DEPTH)) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_new_value      (in_new_value),
    .in_match_value    (in_match_value),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_element_value (out_element_value),
    .out_position      (out_position),
    .out_last_of_run   (out_last_of_run)
  );

  ordered_list_checker #(.DEPTH(DEPTH)) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_new_value      (in_new_value),
    .in_match_value    (in_match_value),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_element_value (out_element_value),
    .out_position      (out_position),
    .out_last_of_run   (out_last_of_run),
    .fail_count        (fail_count),
    .beats_seen        (beats_seen),
    .beats_pending     (beats_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Ends the run if neither a command nor a result beat moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_command(input op_t op, input value_t nv, input value_t mv);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    start          <= 1'b1;
    in_operation   <= op;
    in_new_value   <= nv;
    in_match_value <= mv;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    sent_count++;
  endtask

  task automatic wait_for_drain();
    if (beats_pending != 0) begin
      start <= 1'b0;
      while (beats_pending != 0) @(negedge clk);
    end
  endtask

  // Mostly values from a small pool so that searches and deletes find matches.
  function automatic value_t pick_value();
    if ($urandom_range(99) < 85) return value_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  function automatic op_t pick_operation();
    int r;
    r = $urandom_range(99);
    if (r < 18) return OP_INS_HEAD;
    if (r < 36) return OP_INS_TAIL;
    if (r < 46) return OP_INS_AFTER;
    if (r < 60) return OP_SEARCH;
    if (r < 68) return OP_TRAVERSE;
    if (r < 76) return OP_DEL_HEAD;
    if (r < 84) return OP_DEL_TAIL;
    if (r < 96) return OP_DEL_VALUE;
    if (r < 98) return OP_CLEAR;
    return op_t'($urandom_range(4'hF, OP_CLEAR + 4'd1));
  endfunction

  task automatic refresh_pool();
    for (int i = 0; i < 4; i++) begin
      do value_pool[i] = $urandom; while (value_pool[i] == ABSENT);
    end
    value_pool[4] = 32'h8000_0000;
    value_pool[5] = 32'h7FFF_FFFF;
    value_pool[6] = '0;
    value_pool[7] = '1;
  endtask

  // Fills the pool past its capacity, then probes the full list.
  task automatic fill_and_probe();
    int r;
    send_command(OP_CLEAR, pick_value(), pick_value());
    send_command(OP_INS_HEAD, value_pool[0], pick_value());
    repeat (DEPTH + 5) begin
      r = $urandom_range(99);
      if (r < 40) send_command(OP_INS_HEAD, pick_value(), pick_value());
      else if (r < 80) send_command(OP_INS_TAIL, pick_value(), pick_value());
      else send_command(OP_INS_AFTER, pick_value(), value_pool[0]);
    end
    send_command(OP_INS_AFTER, pick_value(), value_pool[0]);
    send_command(OP_INS_AFTER, pick_value(), ABSENT);
    send_command(OP_TRAVERSE, pick_value(), pick_value());
    send_command(OP_SEARCH, pick_value(), value_pool[0]);
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_operation   = OP_INS_HEAD;
    in_new_value   = '0;
    in_match_value = '0;
    idle_pct       = 0;
    sent_count     = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Every operation that needs a non-empty list, against an empty list first.
    send_command(OP_SEARCH, '0, '0);
    send_command(OP_TRAVERSE, '0, '0);
    send_command(OP_DEL_HEAD, '0, '0);
    send_command(OP_DEL_TAIL, '0, '0);
    send_command(OP_DEL_VALUE, '0, '0);
    send_command(OP_INS_AFTER, '1, '0);
    // Builds 0, MIN, MAX, -1 and then inserts after the tail.
    send_command(OP_INS_HEAD, 32'h8000_0000, '1);
    send_command(OP_INS_TAIL, 32'h7FFF_FFFF, 32'h8000_0000);
    send_command(OP_INS_HEAD, '0, 32'h7FFF_FFFF);
    send_command(OP_INS_TAIL, '1, '1);
    send_command(OP_INS_AFTER, 32'd7, '1);
    send_command(OP_INS_AFTER, 32'd9, ABSENT);
    send_command(OP_SEARCH, '0, '1);
    send_command(OP_SEARCH, '0, ABSENT);
    send_command(OP_TRAVERSE, '0, '0);
    send_command(OP_DEL_VALUE, '0, '0);
    send_command(OP_DEL_VALUE, '0, 32'd7);
    send_command(OP_DEL_VALUE, '0, 32'h7FFF_FFFF);
    send_command(OP_DEL_VALUE, '0, ABSENT);
    send_command(OP_DEL_TAIL, '0, '0);
    send_command(OP_DEL_TAIL, '0, '0);
    send_command(OP_INS_TAIL, 32'd5, '0);
    send_command(OP_DEL_HEAD, '0, '0);
    send_command(op_t'(4'hF), '1, '1);
    send_command(op_t'(OP_CLEAR + 4'd1), '0, '0);
    wait_for_drain();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 0 : (phase == 1) ? 86 : 38;
      refresh_pool();
      fill_and_probe();
      repeat (MIXED_ITEMS) send_command(pick_operation(), pick_value(), pick_value());
      // Let the block run dry before the next idle setting.
      wait_for_drain();
    end

    start <= 1'b0;
    wait_for_drain();
    repeat (40) @(negedge clk);
    $display("Drove %0d commands (empty-list cases, pool fills past capacity, mixed traffic)",
             sent_count);
    $display("under three sender idle settings; %0d result beats were compared.", beats_seen);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[files.f]
src/ole_pkg.sv
src/ole_ram.sv
src/ordered_list_engine_unit.sv
src/ole_chk.sv
dv/ordered_list_checker.sv
dv/tb_ordered_list_engine_unit.sv
